// ===== rtl/core/sff_pkg.sv =====
// Shared types, codes and defaults of the SYN flood flow table.
`timescale 1ns / 1ps

package sff_pkg;

  // Default number of flow slots.
  localparam int unsigned FlowEntriesDefault = 64;

  // Field widths fixed by the word formats.
  localparam int unsigned AddrW  = 32;
  localparam int unsigned PortW  = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;

  // Reset values of the configuration registers.
  localparam logic [CfgW-1:0] SynThresholdReset  = 16'd100;
  localparam logic [CfgW-1:0] WindowSecondsReset = 16'd10;

  // Configuration register indexes.
  localparam logic CfgSynThreshold  = 1'b0;
  localparam logic CfgWindowSeconds = 1'b1;

  // Result codes.
  typedef enum logic [1:0] {
    VERDICT_FULL          = 2'd0,
    VERDICT_ALLOWED       = 2'd1,
    VERDICT_NEW_BLOCKED   = 2'd2,
    VERDICT_STILL_BLOCKED = 2'd3
  } sff_verdict_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_PRUNE,
    ST_UPD1,
    ST_UPD2
  } sff_state_e;

  // One flow slot as held in the table memory.
  typedef struct packed {
    logic              valid;
    logic [AddrW-1:0]  src;
    logic [AddrW-1:0]  dst;
    logic [PortW-1:0]  port;
    logic [CountW-1:0] count;
    logic [TimeW-1:0]  start;
    logic              blocked;
  } sff_entry_t;

endpackage

// ===== rtl/core/sff_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module sff_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/core/sff_expiry.sv =====
// Shared window expiry compare: elapsed time modulo 2^32 against the window.
`timescale 1ns / 1ps

module sff_expiry (
  input  logic [sff_pkg::TimeW-1:0] now_i,
  input  logic [sff_pkg::TimeW-1:0] start_i,
  input  logic [sff_pkg::CfgW-1:0]  window_i,
  output logic                      expired_o
);

  logic [sff_pkg::TimeW-1:0] elapsed;

  // The subtraction wraps naturally, so a time before the start looks long ago.
  assign elapsed   = now_i - start_i;
  assign expired_o = elapsed > {{(sff_pkg::TimeW - sff_pkg::CfgW){1'b0}}, window_i};

endmodule

// ===== rtl/core/syn_flood_flow_table_core.sv =====
// Top level of the SYN flood flow table: sequencer, flow memory and registers.
`timescale 1ns / 1ps

// A SYN event is taken when start_i is high while busy_o is low; exactly one
// word comes back on result_valid_o, verdict_o and syn_total_o, shown for a
// single cycle that the receiver cannot stall. Flows live in one memory of
// FLOW_ENTRIES slots read one slot per cycle. A lookup walks the memory once,
// stopping early when the flow is found, followed by the update states
// ST_UPD1 and ST_UPD2; a new flow arriving at a full table costs a second
// walk that removes expired flows, and the result word is registered at the
// end of the event. After reset the block clears every slot of the memory
// and keeps busy_o high meanwhile; configuration writes are taken at any
// time and cfg_ready_o is always high.
module syn_flood_flow_table_core #(
  parameter int unsigned FLOW_ENTRIES = sff_pkg::FlowEntriesDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Event channel
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [sff_pkg::AddrW-1:0]  source_address_i,
  input  logic [sff_pkg::AddrW-1:0]  dest_address_i,
  input  logic [sff_pkg::PortW-1:0]  dest_port_i,
  input  logic [sff_pkg::TimeW-1:0]  now_seconds_i,
  // Result channel
  output logic                       result_valid_o,
  output logic [1:0]                 verdict_o,
  output logic [sff_pkg::CountW-1:0] syn_total_o,
  // Configuration channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [sff_pkg::CfgW-1:0]   cfg_data_i
);

  localparam int unsigned AW    = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int unsigned CW    = $clog2(FLOW_ENTRIES + 1);
  localparam int unsigned EntW  = $bits(sff_pkg::sff_entry_t);
  localparam logic [CW-1:0] NumEntries = CW'(FLOW_ENTRIES);
  localparam logic [CW-1:0] LastCount  = CW'(FLOW_ENTRIES - 1);
  localparam logic [AW-1:0] LastSlot   = AW'(FLOW_ENTRIES - 1);
  localparam logic [sff_pkg::CountW-1:0] CountMax = '1;

  sff_pkg::sff_state_e state_q, state_d;

  logic [CW-1:0] issue_q, issue_d;
  logic [CW-1:0] occ_q, occ_d;
  logic          rvalid_q;
  logic [AW-1:0] raddr_q;
  logic          free_found_q, free_found_d;
  logic [AW-1:0] free_slot_q, free_slot_d;
  logic [AW-1:0] slot_q, slot_d;
  logic          is_new_q, is_new_d;

  logic [sff_pkg::CountW-1:0] cnt_q, cnt_d;
  logic [sff_pkg::TimeW-1:0]  start_q, start_d;
  logic                       blk_q, blk_d;

  logic [sff_pkg::AddrW-1:0] src_q, dst_q;
  logic [sff_pkg::PortW-1:0] port_q;
  logic [sff_pkg::TimeW-1:0] now_q;

  logic [sff_pkg::CfgW-1:0] thr_q, win_q;

  logic                       result_valid_q, result_valid_d;
  sff_pkg::sff_verdict_e      verdict_q, verdict_d;
  logic [sff_pkg::CountW-1:0] total_q, total_d;

  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  sff_pkg::sff_entry_t mem_wdata, rd_entry;
  logic [EntW-1:0]     mem_rdata;

  logic                      accept;
  logic                      expired;
  logic [sff_pkg::TimeW-1:0] exp_start;
  logic                      key_hit, take_free, kill;
  logic [sff_pkg::CountW-1:0] count_inc;
  logic                       over;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != sff_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign rd_entry    = sff_pkg::sff_entry_t'(mem_rdata);

  // Flow table memory.
  sff_ram #(
    .WIDTH(EntW),
    .DEPTH(FLOW_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(EntW'(mem_wdata)),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Shared expiry compare, used by the prune walk and the update step.
  sff_expiry u_expiry (
    .now_i    (now_q),
    .start_i  (exp_start),
    .window_i (win_q),
    .expired_o(expired)
  );

  // Slot read in the previous cycle matches the key under test.
  assign key_hit = rd_entry.valid && (rd_entry.src == src_q) &&
                   (rd_entry.dst == dst_q) && (rd_entry.port == port_q);
  assign take_free = !rd_entry.valid && !free_found_q;
  assign kill      = rd_entry.valid && expired;

  // Saturating increment and threshold test of the update step.
  assign count_inc = (cnt_q == CountMax) ? cnt_q : cnt_q + 1'b1;
  assign over      = count_inc > thr_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= sff_pkg::SynThresholdReset;
      win_q <= sff_pkg::WindowSecondsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        sff_pkg::CfgSynThreshold:  thr_q <= cfg_data_i;
        sff_pkg::CfgWindowSeconds: win_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Key and time of the event being worked on.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q  <= source_address_i;
      dst_q  <= dest_address_i;
      port_q <= dest_port_i;
      now_q  <= now_seconds_i;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= sff_pkg::ST_CLEAR;
      issue_q        <= '0;
      occ_q          <= '0;
      rvalid_q       <= 1'b0;
      free_found_q   <= 1'b0;
      is_new_q       <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      issue_q        <= issue_d;
      occ_q          <= occ_d;
      rvalid_q       <= mem_re;
      free_found_q   <= free_found_d;
      is_new_q       <= is_new_d;
      result_valid_q <= result_valid_d;
    end
  end

  // Working registers of the current event and the result word.
  always_ff @(posedge clk_i) begin
    raddr_q     <= mem_raddr;
    free_slot_q <= free_slot_d;
    slot_q      <= slot_d;
    cnt_q       <= cnt_d;
    start_q     <= start_d;
    blk_q       <= blk_d;
    verdict_q   <= verdict_d;
    total_q     <= total_d;
  end

  // Sequencer: next state, memory accesses and working register updates.
  always_comb begin
    state_d        = state_q;
    issue_d        = issue_q;
    occ_d          = occ_q;
    free_found_d   = free_found_q;
    free_slot_d    = free_slot_q;
    slot_d         = slot_q;
    is_new_d       = is_new_q;
    cnt_d          = cnt_q;
    start_d        = start_q;
    blk_d          = blk_q;
    result_valid_d = 1'b0;
    verdict_d      = verdict_q;
    total_d        = total_q;
    mem_we         = 1'b0;
    mem_waddr      = raddr_q;
    mem_wdata      = rd_entry;
    mem_re         = 1'b0;
    mem_raddr      = issue_q[AW-1:0];
    exp_start      = start_q;

    case (state_q)
      // Sweep every slot to invalid after reset.
      sff_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = issue_q[AW-1:0];
        mem_wdata = '0;
        if (issue_q == LastCount) begin
          issue_d = '0;
          state_d = sff_pkg::ST_IDLE;
        end else begin
          issue_d = issue_q + 1'b1;
        end
      end

      sff_pkg::ST_IDLE: begin
        if (accept) begin
          issue_d      = '0;
          free_found_d = 1'b0;
          state_d      = sff_pkg::ST_SCAN;
        end
      end

      // Lookup walk: find the flow and remember the lowest free slot.
      sff_pkg::ST_SCAN: begin
        if (issue_q < NumEntries) begin
          mem_re  = 1'b1;
          issue_d = issue_q + 1'b1;
        end
        if (rvalid_q) begin
          if (key_hit) begin
            slot_d   = raddr_q;
            cnt_d    = rd_entry.count;
            start_d  = rd_entry.start;
            blk_d    = rd_entry.blocked;
            is_new_d = 1'b0;
            state_d  = sff_pkg::ST_UPD1;
          end else begin
            if (take_free) begin
              free_found_d = 1'b1;
              free_slot_d  = raddr_q;
            end
            if (raddr_q == LastSlot) begin
              if (occ_q < NumEntries) begin
                slot_d   = take_free ? raddr_q : free_slot_q;
                cnt_d    = '0;
                start_d  = now_q;
                blk_d    = 1'b0;
                is_new_d = 1'b1;
                state_d  = sff_pkg::ST_UPD1;
              end else begin
                issue_d      = '0;
                free_found_d = 1'b0;
                state_d      = sff_pkg::ST_PRUNE;
              end
            end
          end
        end
      end

      // Prune walk: drop every expired flow, keep the lowest freed slot.
      sff_pkg::ST_PRUNE: begin
        exp_start = rd_entry.start;
        if (issue_q < NumEntries) begin
          mem_re  = 1'b1;
          issue_d = issue_q + 1'b1;
        end
        if (rvalid_q) begin
          if (kill) begin
            mem_we          = 1'b1;
            mem_wdata.valid = 1'b0;
            occ_d           = occ_q - 1'b1;
            if (!free_found_q) begin
              free_found_d = 1'b1;
              free_slot_d  = raddr_q;
            end
          end
          if (raddr_q == LastSlot) begin
            if (free_found_q || kill) begin
              slot_d   = free_found_q ? free_slot_q : raddr_q;
              cnt_d    = '0;
              start_d  = now_q;
              blk_d    = 1'b0;
              is_new_d = 1'b1;
              state_d  = sff_pkg::ST_UPD1;
            end else begin
              result_valid_d = 1'b1;
              verdict_d      = sff_pkg::VERDICT_FULL;
              total_d        = '0;
              state_d        = sff_pkg::ST_IDLE;
            end
          end
        end
      end

      // Restart the window if it has run out.
      sff_pkg::ST_UPD1: begin
        if (expired) begin
          cnt_d   = '0;
          start_d = now_q;
          blk_d   = 1'b0;
        end
        state_d = sff_pkg::ST_UPD2;
      end

      // Count, judge, write the slot back and deliver the word.
      sff_pkg::ST_UPD2: begin
        mem_we            = 1'b1;
        mem_waddr         = slot_q;
        mem_wdata.valid   = 1'b1;
        mem_wdata.src     = src_q;
        mem_wdata.dst     = dst_q;
        mem_wdata.port    = port_q;
        mem_wdata.count   = count_inc;
        mem_wdata.start   = start_q;
        mem_wdata.blocked = blk_q || over;
        result_valid_d    = 1'b1;
        total_d           = count_inc;
        if (!over) begin
          verdict_d = sff_pkg::VERDICT_ALLOWED;
        end else if (blk_q) begin
          verdict_d = sff_pkg::VERDICT_STILL_BLOCKED;
        end else begin
          verdict_d = sff_pkg::VERDICT_NEW_BLOCKED;
        end
        if (is_new_q) begin
          occ_d = occ_q + 1'b1;
        end
        state_d = sff_pkg::ST_IDLE;
      end

      default: begin
        state_d = sff_pkg::ST_IDLE;
      end
    endcase
  end

  assign result_valid_o = result_valid_q;
  assign verdict_o      = verdict_q;
  assign syn_total_o    = total_q;

`ifndef NO_ASSERTIONS
  // Occupancy never exceeds the number of slots.
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= NumEntries)
    else $error("occupancy above table size");

  // A word is only produced at the end of the update or prune walk.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(state_q) == sff_pkg::ST_UPD2 ||
                        $past(state_q) == sff_pkg::ST_PRUNE))
    else $error("result word without a finished event");

  // A table-full word carries a zero count.
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && verdict_o == sff_pkg::VERDICT_FULL) |-> (syn_total_o == '0))
    else $error("table-full word with a non-zero count");

  // An accepted event starts the lookup walk.
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == sff_pkg::ST_SCAN))
    else $error("accepted event did not start a lookup");

  // The prune walk only ever invalidates slots.
  a_prune_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sff_pkg::ST_PRUNE && mem_we) |-> !mem_wdata.valid)
    else $error("prune walk wrote a valid slot");
`endif

endmodule
